@@ sv/resource_limit_accounting_macros.svh @@
// Assertion macros for the resource limit accounting block.
// Used by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef RESOURCE_LIMIT_ACCOUNTING_MACROS_SVH
`define RESOURCE_LIMIT_ACCOUNTING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rla_pkg.sv @@
// Shared types and constants for the resource limit accounting block.
// No dependencies; imported by every module of the block except rla_ram.
package rla_pkg;

    localparam int FIELD_W = 63;   // width of every value field on the ports
    localparam int OP_W    = 3;
    localparam int RES_W   = 3;
    localparam int STAT_W  = 3;

    localparam int NUM_RESOURCES_DEF = 8;
    localparam int VALUE_BITS_DEF    = 63;

    localparam logic [OP_W-1:0] OP_QUERY   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_LIM = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd2;
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 3'd2;
    localparam logic [STAT_W-1:0] ST_WAIT    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FAULT   = 3'd4;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch the input transaction, start the table read
        logic commit;    // write back the entry and load the result register
    } t_cmd;

endpackage

@@ sv/resource_limit_accounting.sv @@
// Top level of the resource limit accounting block.
// Depends on rla_pkg, rla_ctrl, rla_dp (which holds rla_ram) and the macros header.

// Per-resource accounting table. Each resource keeps a limit, current use,
// hinted use and peak, all zero after reset. One input transaction carries
// an operation (query, set limit, add, reserve, release) on one resource and
// produces exactly one result transaction with the status and the limit,
// current, peak and free amount after the operation; a successful release
// also raises wake_waiters. For each transaction the accept edge launches
// the table RAM read; a later edge, once the result register is free,
// writes the updated entry back and loads the result register. The block
// takes no new transaction while one is in execution and holds execution
// while the result register still waits to be drained; a result that sits
// in the output register does not block the next accept.
// The input is stalled while reset is applied.
// Entries start out marked unwritten and read as zero, so no clearing pass
// is needed after reset. The dynamic_add_enable register (i_cfg_we, i_cfg_wdata)
// enables the add operation. The user must write it only while idle; the block does not enforce this.
`include "resource_limit_accounting_macros.svh"

module resource_limit_accounting import rla_pkg::*; #(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [RES_W-1:0]   i_resource,
    input  logic [FIELD_W-1:0] i_amount,
    input  logic [FIELD_W-1:0] i_hint_amount,
    input  logic               i_deadline_passed,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [FIELD_W-1:0] o_limit_value,
    output logic [FIELD_W-1:0] o_current_value,
    output logic [FIELD_W-1:0] o_peak_value,
    output logic [FIELD_W-1:0] o_free_value,
    output logic               o_wake_waiters
);

    t_cmd cmd;

    // Sequence each transaction: capture, then execute and hand off.
    rla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Table storage, entry update and result register.
    rla_dp #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_operation       (i_operation),
        .i_resource        (i_resource),
        .i_amount          (i_amount),
        .i_hint_amount     (i_hint_amount),
        .i_deadline_passed (i_deadline_passed),
        .o_status          (o_status),
        .o_limit_value     (o_limit_value),
        .o_current_value   (o_current_value),
        .o_peak_value      (o_peak_value),
        .o_free_value      (o_free_value),
        .o_wake_waiters    (o_wake_waiters)
    );

    // An accepted transaction keeps the input side busy for its execute cycle.
    `RLA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "no busy after accept")

    // Returning to idle outside reset exit means a result was just loaded.
    `RLA_ASSERT_NOW(a_result_on_idle, $fell(o_in_stall) && $past(i_rst_n), o_out_valid, "no result")

    // Wake only accompanies a successful release.
    `RLA_ASSERT_NOW(a_wake_ok, o_out_valid && o_wake_waiters, o_status == ST_OK, "wake on failure")

endmodule

@@ sv/rla_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rla_ctrl.sv @@
// Controller for the resource limit accounting block: accept, execute, hand off.
// Depends on rla_pkg for the command struct.
module rla_ctrl import rla_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    // Result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                // hold the input off while reset is applied
                o_in_stall    = !i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold here until the result register frees up
                o_cmd.commit = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/rla_dp.sv @@
// Datapath for the resource limit accounting block: table RAM, entry update,
// result register. Depends on rla_pkg and rla_ram.
module rla_dp import rla_pkg::*; #(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [RES_W-1:0]   i_resource,
    input  logic [FIELD_W-1:0] i_amount,
    input  logic [FIELD_W-1:0] i_hint_amount,
    input  logic               i_deadline_passed,
    output logic [STAT_W-1:0]  o_status,
    output logic [FIELD_W-1:0] o_limit_value,
    output logic [FIELD_W-1:0] o_current_value,
    output logic [FIELD_W-1:0] o_peak_value,
    output logic [FIELD_W-1:0] o_free_value,
    output logic               o_wake_waiters
);

    localparam int W     = VALUE_BITS;
    localparam int IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

    logic               r_add_en;
    logic [OP_W-1:0]    r_op;
    logic [RES_W-1:0]   r_res;
    logic [W-1:0]       r_amt;
    logic [W-1:0]       r_hamt;
    logic               r_expired;
    logic [NUM_RESOURCES-1:0] r_valid;

    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   rd_addr;
    logic [4*W-1:0]     rd_data;
    logic [4*W-1:0]     wr_data;
    logic               in_range;
    logic               entry_valid;
    logic               wr_en;

    logic [W-1:0] lim, cur, hnt, pk;
    logic [W-1:0] n_lim, n_cur, n_hnt, n_pk;
    logic [STAT_W-1:0] n_status;
    logic n_wake;
    logic chain_ok;
    logic [W:0] lim_plus, cur_plus, hnt_plus;

    logic [STAT_W-1:0] r_status;
    logic [W-1:0]      r_lim_o, r_cur_o, r_pk_o;
    logic              r_wake;

    assign idx      = IDX_W'(r_res);
    assign in_range = (32'(r_res) < NUM_RESOURCES);
    assign rd_addr  = i_cmd.capture ? IDX_W'(i_resource) : idx;

    rla_ram #(
        .WIDTH (4*W),
        .DEPTH (NUM_RESOURCES),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (idx),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Entries never written read as zero.
    assign entry_valid = in_range && r_valid[idx];
    assign lim = entry_valid ? rd_data[W-1:0]     : '0;
    assign cur = entry_valid ? rd_data[2*W-1:W]   : '0;
    assign hnt = entry_valid ? rd_data[3*W-1:2*W] : '0;
    assign pk  = entry_valid ? rd_data[4*W-1:3*W] : '0;

    assign chain_ok = (cur <= pk) && (pk <= lim) && (hnt <= cur);
    assign lim_plus = {1'b0, lim} + {1'b0, r_amt};
    assign cur_plus = {1'b0, cur} + {1'b0, r_amt};
    assign hnt_plus = {1'b0, hnt} + {1'b0, r_amt};

    always_comb begin
        n_lim    = lim;
        n_cur    = cur;
        n_hnt    = hnt;
        n_pk     = pk;
        n_status = ST_OK;
        n_wake   = 1'b0;
        case (r_op)
            OP_QUERY: begin
                if (!chain_ok) begin
                    n_status = ST_FAULT;
                end
            end
            OP_SET_LIM: begin
                if (cur > r_amt) begin
                    n_status = ST_INVALID;
                end else begin
                    n_lim = r_amt;
                    n_pk  = cur;
                end
            end
            OP_ADD: begin
                if (!r_add_en || (r_amt == '0) || !chain_ok || lim_plus[W]) begin
                    n_status = ST_FAULT;
                end else begin
                    n_lim = lim_plus[W-1:0];
                    n_cur = cur_plus[W-1:0];
                    n_hnt = hnt_plus[W-1:0];
                    if (pk < cur_plus[W-1:0]) begin
                        n_pk = cur_plus[W-1:0];
                    end
                end
            end
            OP_RESERVE: begin
                if (hnt > cur) begin
                    n_status = ST_FAULT;
                end else if (hnt >= lim) begin
                    n_status = ST_REFUSED;
                end else if (cur > lim) begin
                    n_status = ST_FAULT;
                end else if ((r_amt == '0) || cur_plus[W]) begin
                    n_status = ST_REFUSED;
                end else if (cur_plus <= {1'b0, lim}) begin
                    n_cur = cur_plus[W-1:0];
                    n_hnt = hnt_plus[W-1:0];
                    if (pk < cur_plus[W-1:0]) begin
                        n_pk = cur_plus[W-1:0];
                    end
                end else if ((hnt_plus <= {1'b0, lim}) && !r_expired) begin
                    n_status = ST_WAIT;
                end else begin
                    n_status = ST_REFUSED;
                end
            end
            OP_RELEASE: begin
                if ((cur > lim) || (hnt > cur) || (r_amt > cur) || (r_hamt > hnt)) begin
                    n_status = ST_FAULT;
                end else begin
                    n_cur  = cur - r_amt;
                    n_hnt  = hnt - r_hamt;
                    n_wake = 1'b1;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    assign wr_en   = i_cmd.commit && in_range;
    assign wr_data = {n_pk, n_hnt, n_cur, n_lim};

    // Control state: config bit and per-entry valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_en <= 1'b0;
            r_valid  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_add_en <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_valid[idx] <= 1'b1;
            end
        end
    end

    // Input capture and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_operation;
            r_res     <= i_resource;
            r_amt     <= i_amount[W-1:0];
            r_hamt    <= i_hint_amount[W-1:0];
            r_expired <= i_deadline_passed;
        end
        if (i_cmd.commit) begin
            if (in_range) begin
                r_status <= n_status;
                r_lim_o  <= n_lim;
                r_cur_o  <= n_cur;
                r_pk_o   <= n_pk;
                r_wake   <= n_wake;
            end else begin
                r_status <= ST_INVALID;
                r_lim_o  <= '0;
                r_cur_o  <= '0;
                r_pk_o   <= '0;
                r_wake   <= 1'b0;
            end
        end
    end

    assign o_status        = r_status;
    assign o_limit_value   = FIELD_W'(r_lim_o);
    assign o_current_value = FIELD_W'(r_cur_o);
    assign o_peak_value    = FIELD_W'(r_pk_o);
    assign o_free_value    = (r_lim_o >= r_cur_o) ? FIELD_W'(r_lim_o - r_cur_o) : '0;
    assign o_wake_waiters  = r_wake;

endmodule

@@ bench/rla_account_checker.sv @@
// Checker for the resource limit accounting block: predicts every result and compares it.
// Depends on rla_pkg; instantiated beside the block by tb_resource_limit_accounting.
`timescale 1ns / 1ps

module rla_account_checker import rla_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [RES_W-1:0]   i_resource,
    input  logic [FIELD_W-1:0] i_amount,
    input  logic [FIELD_W-1:0] i_hint_amount,
    input  logic               i_deadline_passed,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [STAT_W-1:0]  i_status,
    input  logic [FIELD_W-1:0] i_limit_value,
    input  logic [FIELD_W-1:0] i_current_value,
    input  logic [FIELD_W-1:0] i_peak_value,
    input  logic [FIELD_W-1:0] i_free_value,
    input  logic               i_wake_waiters,
    output int                 o_outstanding,
    output int                 o_fail_count
);

    typedef logic [FIELD_W:0] t_wide;   // one spare bit to see overflow

    localparam t_wide VALUE_MAX = {1'b0, {FIELD_W{1'b1}}};

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FIELD_W-1:0] limit_v;
        logic [FIELD_W-1:0] current_v;
        logic [FIELD_W-1:0] peak_v;
        logic [FIELD_W-1:0] free_v;
        logic               wake;
    } t_account_result;

    logic [FIELD_W-1:0] limit_tab   [NUM_RESOURCES_DEF];
    logic [FIELD_W-1:0] current_tab [NUM_RESOURCES_DEF];
    logic [FIELD_W-1:0] hint_tab    [NUM_RESOURCES_DEF];
    logic [FIELD_W-1:0] peak_tab    [NUM_RESOURCES_DEF];
    logic               add_enable;
    t_account_result    pending_results [$];
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report(input string what, input t_wide got, input t_wide want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Apply one operation to the shadow tables and return the result it produces.
    function automatic t_account_result apply_operation(
        input logic [OP_W-1:0]    op,
        input logic [RES_W-1:0]   res,
        input logic [FIELD_W-1:0] amount,
        input logic [FIELD_W-1:0] hint_amount,
        input logic               expired
    );
        t_wide           lim, cur, hnt, pk, amt, hamt, sum;
        logic            chain_ok;
        t_account_result r;
        r = '0;
        if (res >= NUM_RESOURCES_DEF) begin
            r.status = ST_INVALID;
            return r;
        end
        lim  = {1'b0, limit_tab[res]};
        cur  = {1'b0, current_tab[res]};
        hnt  = {1'b0, hint_tab[res]};
        pk   = {1'b0, peak_tab[res]};
        amt  = {1'b0, amount};
        hamt = {1'b0, hint_amount};
        chain_ok = (cur <= pk) && (pk <= lim) && (hnt <= cur);
        r.status = ST_OK;
        case (op)
            OP_QUERY: begin
                if (!chain_ok) r.status = ST_FAULT;
            end
            OP_SET_LIM: begin
                if (cur > amt) begin
                    r.status = ST_INVALID;
                end else begin
                    lim = amt;
                    pk  = cur;
                end
            end
            OP_ADD: begin
                if (!add_enable || amt == 0 || !chain_ok || lim + amt > VALUE_MAX) begin
                    r.status = ST_FAULT;
                end else begin
                    lim = lim + amt;
                    cur = cur + amt;
                    hnt = hnt + amt;
                    if (pk < cur) pk = cur;
                end
            end
            OP_RESERVE: begin
                sum = cur + amt;
                if (hnt > cur) begin
                    r.status = ST_FAULT;
                end else if (hnt >= lim) begin
                    r.status = ST_REFUSED;
                end else if (cur > lim) begin
                    r.status = ST_FAULT;
                end else if (amt == 0 || sum > VALUE_MAX) begin
                    r.status = ST_REFUSED;
                end else if (sum <= lim) begin
                    cur = sum;
                    hnt = hnt + amt;
                    if (pk < sum) pk = sum;
                end else if (hnt + amt <= lim && !expired) begin
                    r.status = ST_WAIT;
                end else begin
                    r.status = ST_REFUSED;
                end
            end
            OP_RELEASE: begin
                if (cur > lim || hnt > cur || amt > cur || hamt > hnt) begin
                    r.status = ST_FAULT;
                end else begin
                    cur    = cur - amt;
                    hnt    = hnt - hamt;
                    r.wake = 1'b1;
                end
            end
            default: r.status = ST_INVALID;
        endcase
        limit_tab[res]   = lim[FIELD_W-1:0];
        current_tab[res] = cur[FIELD_W-1:0];
        hint_tab[res]    = hnt[FIELD_W-1:0];
        peak_tab[res]    = pk[FIELD_W-1:0];
        r.limit_v   = lim[FIELD_W-1:0];
        r.current_v = cur[FIELD_W-1:0];
        r.peak_v    = pk[FIELD_W-1:0];
        r.free_v    = (lim >= cur) ? lim[FIELD_W-1:0] - cur[FIELD_W-1:0] : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_account_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_RESOURCES_DEF; i++) begin
                limit_tab[i]   = '0;
                current_tab[i] = '0;
                hint_tab[i]    = '0;
                peak_tab[i]    = '0;
            end
            add_enable = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) add_enable = i_cfg_wdata;
            // Compare the result leaving the block before predicting the new one.
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report("unexpected result, status", t_wide'(i_status), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status)
                        report("status", t_wide'(i_status), t_wide'(want.status));
                    if (i_limit_value !== want.limit_v)
                        report("limit_value", t_wide'(i_limit_value), t_wide'(want.limit_v));
                    if (i_current_value !== want.current_v)
                        report("current_value", t_wide'(i_current_value),
                               t_wide'(want.current_v));
                    if (i_peak_value !== want.peak_v)
                        report("peak_value", t_wide'(i_peak_value), t_wide'(want.peak_v));
                    if (i_free_value !== want.free_v)
                        report("free_value", t_wide'(i_free_value), t_wide'(want.free_v));
                    if (i_wake_waiters !== want.wake)
                        report("wake_waiters", t_wide'(i_wake_waiters), t_wide'(want.wake));
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(apply_operation(i_operation, i_resource, i_amount,
                                                          i_hint_amount, i_deadline_passed));
        end
        o_outstanding <= pending_results.size();
    end

endmodule

@@ bench/tb_resource_limit_accounting.sv @@
// Top of the resource limit accounting testbench: clock, reset, stimulus and verdict.
// Depends on rla_pkg, resource_limit_accounting and rla_account_checker.
`timescale 1ns / 1ps

module tb_resource_limit_accounting;
    import rla_pkg::*;

    localparam int                 ITEMS_PER_PHASE = 500;
    localparam int                 CYCLE_LIMIT     = 600000;
    localparam logic [FIELD_W-1:0] VMAX            = '1;
    localparam logic [RES_W-1:0]   BROKEN_RES      = 3'd7;   // kept with hint above current
    localparam logic [RES_W-1:0]   LAST_WELL_RES   = 3'd6;
    localparam logic [OP_W-1:0]    OP_CODE_MAX     = 3'd7;   // codes past release are undefined

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_operation;
    logic [RES_W-1:0]   i_resource;
    logic [FIELD_W-1:0] i_amount;
    logic [FIELD_W-1:0] i_hint_amount;
    logic               i_deadline_passed;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [FIELD_W-1:0] o_limit_value;
    logic [FIELD_W-1:0] o_current_value;
    logic [FIELD_W-1:0] o_peak_value;
    logic [FIELD_W-1:0] o_free_value;
    logic               o_wake_waiters;

    int outstanding;
    int fail_count;
    int cycle_count = 0;
    int idle_pct    = 0;    // chance in a hundred that the sender holds off a cycle
    int stall_pct   = 0;    // chance in a hundred that the receiver stalls a cycle

    // Idling plan per random phase: none, sender idle, receiver stalling, both.
    int idle_plan  [4] = '{0, 80, 0, 17};
    int stall_plan [4] = '{0, 0, 80, 17};

    resource_limit_accounting dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_resource        (i_resource),
        .i_amount          (i_amount),
        .i_hint_amount     (i_hint_amount),
        .i_deadline_passed (i_deadline_passed),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_limit_value     (o_limit_value),
        .o_current_value   (o_current_value),
        .o_peak_value      (o_peak_value),
        .o_free_value      (o_free_value),
        .o_wake_waiters    (o_wake_waiters)
    );

    rla_account_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_resource        (i_resource),
        .i_amount          (i_amount),
        .i_hint_amount     (i_hint_amount),
        .i_deadline_passed (i_deadline_passed),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_status          (o_status),
        .i_limit_value     (o_limit_value),
        .i_current_value   (o_current_value),
        .i_peak_value      (o_peak_value),
        .i_free_value      (o_free_value),
        .i_wake_waiters    (o_wake_waiters),
        .o_outstanding     (outstanding),
        .o_fail_count      (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: stall at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Full-width random value, so every bit of a field sees both levels.
    function automatic logic [FIELD_W-1:0] wide_random();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[FIELD_W-1:0];
    endfunction

    // Mostly a value in [lo, hi]; now and then a full-width value or the maximum.
    function automatic logic [FIELD_W-1:0] scaled_value(input int lo, input int hi);
        int pick;
        pick = $urandom_range(31);
        if (pick == 0) return VMAX;
        if (pick < 3) return wide_random();
        return FIELD_W'($urandom_range(hi, lo));
    endfunction

    // Drive one transaction and hold it until the block takes it. Returns at the
    // accept edge with valid still high, so back-to-back transactions keep it up.
    task automatic send_item(
        input logic [OP_W-1:0]    op,
        input logic [RES_W-1:0]   res,
        input logic [FIELD_W-1:0] amt,
        input logic [FIELD_W-1:0] hamt,
        input logic               expired
    );
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_operation       <= op;
        i_resource        <= res;
        i_amount          <= amt;
        i_hint_amount     <= hamt;
        i_deadline_passed <= expired;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every predicted result has been seen,
    // then let the block settle before returning.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_add_enable(input logic value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random transaction. Well-formed traffic goes to resources 0..6 and
    // releases never take less off the hint than off current use, so those
    // resources keep hint <= current and stay out of the stuck fault state.
    // A small share of raw noise goes to the resource already broken.
    task automatic random_item();
        logic [RES_W-1:0]   res;
        logic [FIELD_W-1:0] amt;
        logic [FIELD_W-1:0] hamt;
        logic               expired;
        int                 pick;
        pick    = $urandom_range(99);
        res     = RES_W'($urandom_range(LAST_WELL_RES));
        hamt    = wide_random();
        expired = 1'($urandom_range(1));
        if (pick < 4) begin
            send_item(OP_W'($urandom_range(OP_CODE_MAX)), BROKEN_RES, wide_random(), hamt,
                      expired);
        end else if (pick < 14) begin
            send_item(OP_QUERY, res, wide_random(), hamt, expired);
        end else if (pick < 29) begin
            send_item(OP_SET_LIM, res, scaled_value(0, 2000), hamt, expired);
        end else if (pick < 40) begin
            send_item(OP_ADD, res, scaled_value(0, 200), hamt, expired);
        end else if (pick < 72) begin
            send_item(OP_RESERVE, res, scaled_value(0, 400), hamt, expired);
        end else if (pick < 96) begin
            amt  = scaled_value(0, 300);
            hamt = amt + FIELD_W'($urandom_range(30));
            if (hamt < amt) hamt = VMAX;   // clamp the wrap
            send_item(OP_RELEASE, res, amt, hamt, expired);
        end else begin
            send_item(OP_W'($urandom_range(OP_CODE_MAX, OP_RELEASE + 1)), res, wide_random(),
                      hamt, expired);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        i_in_valid        = 1'b0;
        i_operation       = OP_QUERY;
        i_resource        = '0;
        i_amount          = '0;
        i_hint_amount     = '0;
        i_deadline_passed = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, add still disabled from reset.
        send_item(OP_QUERY,   3'd0, '0, '0, 1'b0);             // clean table passes
        send_item(OP_ADD,     3'd0, 63'd5, '0, 1'b0);          // add disabled
        send_item(OP_SET_LIM, 3'd0, 63'd100, '0, 1'b0);
        send_item(OP_RESERVE, 3'd0, '0, '0, 1'b0);             // zero amount refused
        send_item(OP_RESERVE, 3'd0, 63'd60, '0, 1'b0);         // granted
        send_item(OP_RELEASE, 3'd0, 63'd20, 63'd40, 1'b0);     // hint drops below current
        send_item(OP_RESERVE, 3'd0, 63'd70, '0, 1'b0);         // only the hint fits: wait
        send_item(OP_RESERVE, 3'd0, 63'd70, '0, 1'b1);         // same, deadline gone
        send_item(OP_SET_LIM, 3'd0, 63'd30, '0, 1'b0);         // below current use
        send_item(OP_SET_LIM, 3'd0, 63'd40, '0, 1'b0);         // peak follows current
        send_item(OP_RESERVE, 3'd0, VMAX, '0, 1'b0);           // sum leaves the range
        send_item(OP_RELEASE, 3'd0, 63'd50, '0, 1'b0);         // more than current
        send_item(OP_RELEASE, 3'd0, '0, 63'd30, 1'b0);         // more than the hint
        send_item(OP_W'(OP_RELEASE + 1), 3'd1, VMAX, VMAX, 1'b1);  // undefined operations
        send_item(OP_CODE_MAX, 3'd2, VMAX, VMAX, 1'b1);
        send_item(OP_SET_LIM, 3'd1, VMAX, '0, 1'b0);
        send_item(OP_RESERVE, 3'd1, VMAX, '0, 1'b0);           // fills to the top
        send_item(OP_RELEASE, 3'd1, VMAX, VMAX, 1'b0);
        send_item(OP_RESERVE, 3'd5, 63'd1, '0, 1'b0);          // hint at the limit

        write_add_enable(1'b1);
        send_item(OP_ADD,     3'd2, '0, '0, 1'b0);             // zero increase
        send_item(OP_ADD,     3'd2, 63'd10, '0, 1'b0);
        send_item(OP_SET_LIM, 3'd3, VMAX - 63'd1, '0, 1'b0);
        send_item(OP_ADD,     3'd3, 63'd5, '0, 1'b0);          // limit would overflow
        // Leave one resource with hint above current: query, add, reserve and release all fault there.
        send_item(OP_SET_LIM, BROKEN_RES, 63'd50, '0, 1'b0);
        send_item(OP_RESERVE, BROKEN_RES, 63'd30, '0, 1'b0);
        send_item(OP_RELEASE, BROKEN_RES, 63'd30, '0, 1'b0);
        send_item(OP_QUERY,   BROKEN_RES, '0, '0, 1'b0);
        send_item(OP_RESERVE, BROKEN_RES, 63'd5, '0, 1'b0);

        // Random part: flip the add enable at every phase change and pause
        // halfway through each phase until the block has answered everything.
        for (int phase = 0; phase < 4; phase++) begin
            write_add_enable(phase[0]);
            idle_pct  = idle_plan[phase];
            stall_pct <= stall_plan[phase];
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) drain();
                random_item();
            end
        end

        drain();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
